### hdl/tpd_pkg.sv
`default_nettype none

package tpd_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 16;
  localparam int REQ_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_LANES = 2;

  // Default calibration length
  localparam int CALIB_SAMPLES_DEF = 32;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CALIB = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FETCH = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_CH0  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_CH1  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INT = 2'd2;

  localparam logic [COUNT_W-1:0] SCAN_INT_RST = 16'd10;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic                channel;
  } tpd_in_t;

  typedef struct packed {
    logic               scanned;
    logic               touched_ch0;
    logic               touched_ch1;
    logic [COUNT_W-1:0] count_ch0;
    logic [COUNT_W-1:0] count_ch1;
    logic [COUNT_W-1:0] fetched_time;
    logic               calib_done;
  } tpd_out_t;

  // Control from the sequencer to one lane
  typedef struct packed {
    logic s1_en;        // stage 1 load
    logic s2_en;        // stage 2 load
    logic upd;          // stage 2 item commits to state
    logic calib;
    logic calib_first;
    logic calib_last;
    logic scan;
    logic fetch;
  } tpd_lane_ctl_t;

  // What one lane reports to the merge stage
  typedef struct packed {
    logic               touched;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] stored;
  } tpd_lane_res_t;

endpackage

`default_nettype wire

### hdl/touch_pad_duration_detector_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_data  (tpd_in_t)
// out     | output    | out_valid / out_ready | out_data (tpd_out_t)
// cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// One item per cycle sustained while the output is not stalled; each result passes
// through the two-stage reciprocal multiply in each lane and then the output register.
// All state commits as an item leaves stage 2, so items update state strictly in order.
// rst_n is synchronous, active low; it clears pipeline valids and all detector state.
// A stalled output holds the pipeline; input ready stays high while any stage is free.
`default_nettype none

module touch_pad_duration_detector_unit
  import tpd_pkg::*;
#(
  parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tpd_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tpd_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (CALIB_SAMPLES > 1) ? $clog2(CALIB_SAMPLES) : 1;

  // Configuration registers
  logic [COUNT_W-1:0] thr0_r, thr1_r, scan_int_r;

  // Pipeline valids and item control fields
  logic             v1_r, v2_r, vo_r;
  logic [REQ_W-1:0] req1_r, req2_r;
  logic             ch1_r, ch2_r;
  logic             adv1, adv2, adv_o;

  // Sequencer state
  logic [COUNT_W-1:0] presc_r, presc_nxt;
  logic [IDX_W-1:0]   calib_idx_r, calib_idx_nxt;

  logic               is_calib, is_tick, is_fetch;
  logic               calib_first, calib_last;
  logic [COUNT_W:0]   presc_inc;
  logic               scan;

  tpd_lane_ctl_t      lane_ctl [NUM_LANES];
  tpd_lane_res_t      lane_res [NUM_LANES];
  logic [SAMPLE_W-1:0] lane_sample [NUM_LANES];
  logic [COUNT_W-1:0] lane_thr [NUM_LANES];

  tpd_out_t           out_data_r, out_nxt;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr0_r     <= '0;
      thr1_r     <= '0;
      scan_int_r <= SCAN_INT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THR_CH0:  thr0_r     <= cfg_wdata;
        CFG_THR_CH1:  thr1_r     <= cfg_wdata;
        CFG_SCAN_INT: scan_int_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the pipeline from the output side back
  assign adv_o    = v2_r && (!vo_r || out_ready);
  assign adv2     = v1_r && (!v2_r || adv_o);
  assign in_ready = !v1_r || adv2;
  assign adv1     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= adv1 || (v1_r && !adv2);
      v2_r <= adv2 || (v2_r && !adv_o);
      vo_r <= adv_o || (vo_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      req1_r <= in_data.req_type;
      ch1_r  <= in_data.channel;
    end
    if (adv2) begin
      req2_r <= req1_r;
      ch2_r  <= ch1_r;
    end
  end

  // Decode the item in stage 2
  assign is_calib    = req2_r == REQ_CALIB;
  assign is_tick     = req2_r == REQ_TICK;
  assign is_fetch    = req2_r == REQ_FETCH;
  assign calib_first = calib_idx_r == '0;
  assign calib_last  = calib_idx_r == IDX_W'(CALIB_SAMPLES - 1);
  assign presc_inc   = {1'b0, presc_r} + 1'b1;
  assign scan        = is_tick && (presc_inc > {1'b0, scan_int_r});

  // Next prescaler and calibration index
  always_comb begin
    presc_nxt     = presc_r;
    calib_idx_nxt = calib_idx_r;
    if (adv_o) begin
      if (is_calib) begin
        calib_idx_nxt = calib_last ? '0 : calib_idx_r + 1'b1;
      end
      if (is_tick) begin
        presc_nxt = scan ? '0 : presc_inc[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r     <= '0;
      calib_idx_r <= '0;
    end else begin
      presc_r     <= presc_nxt;
      calib_idx_r <= calib_idx_nxt;
    end
  end

  assign lane_sample[0] = in_data.sample_ch0;
  assign lane_sample[1] = in_data.sample_ch1;
  assign lane_thr[0]    = thr0_r;
  assign lane_thr[1]    = thr1_r;

  // One lane per channel
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign lane_ctl[g].s1_en       = adv1;
    assign lane_ctl[g].s2_en       = adv2;
    assign lane_ctl[g].upd         = adv_o;
    assign lane_ctl[g].calib       = is_calib;
    assign lane_ctl[g].calib_first = calib_first;
    assign lane_ctl[g].calib_last  = calib_last;
    assign lane_ctl[g].scan        = scan;
    assign lane_ctl[g].fetch       = is_fetch && (ch2_r == 1'(g));

    tpd_lane #(
      .CALIB_SAMPLES(CALIB_SAMPLES)
    ) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (lane_ctl[g]),
      .sample_in    (lane_sample[g]),
      .thr          (lane_thr[g]),
      .scan_interval(scan_int_r),
      .res          (lane_res[g])
    );
  end

  // Merge lane results into one result
  always_comb begin
    out_nxt.scanned      = scan;
    out_nxt.touched_ch0  = scan && lane_res[0].touched;
    out_nxt.touched_ch1  = scan && lane_res[1].touched;
    out_nxt.count_ch0    = lane_res[0].count;
    out_nxt.count_ch1    = lane_res[1].count;
    out_nxt.fetched_time = '0;
    if (is_fetch) begin
      out_nxt.fetched_time = ch2_r ? lane_res[1].stored : lane_res[0].stored;
    end
    out_nxt.calib_done   = is_calib && calib_last;
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("transfer did not load stage 1");

  a_calib_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_o && is_calib && calib_last) |=> (calib_idx_r == '0))
    else $error("calibration index did not restart");

  a_scan_presc: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_o && scan) |=> (presc_r == '0))
    else $error("prescaler not cleared after scan");

  a_touch_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && (out_data_r.touched_ch0 || out_data_r.touched_ch1)) |-> out_data_r.scanned)
    else $error("touch reported without scan");

  a_fetch_only: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && (out_data_r.fetched_time != '0))
      |-> (!out_data_r.scanned && !out_data_r.calib_done))
    else $error("fetched time on a non-fetch result");
`endif

endmodule

`default_nettype wire

### hdl/tpd_lane.sv
`default_nettype none

module tpd_lane
  import tpd_pkg::*;
#(
  parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tpd_lane_ctl_t       ctl,
  input  wire logic [SAMPLE_W-1:0] sample_in,
  input  wire logic [COUNT_W-1:0]  thr,
  input  wire logic [COUNT_W-1:0]  scan_interval,
  output tpd_lane_res_t            res
);

  // Remainder width and reciprocal constant for the division by CALIB_SAMPLES
  localparam int R_W    = (CALIB_SAMPLES > 1) ? $clog2(CALIB_SAMPLES) : 1;
  localparam int MUL_SH = SAMPLE_W + R_W;
  localparam int MUL_W  = SAMPLE_W + 1;
  localparam int PROD_W = SAMPLE_W + MUL_W;
  localparam int QN_W   = SAMPLE_W + R_W + 1;
  localparam logic [MUL_W-1:0] MUL_K =
    MUL_W'(((64'd1 << MUL_SH) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

  logic [SAMPLE_W-1:0] s1_r;
  logic [PROD_W-1:0]   prod1_r;
  logic [SAMPLE_W-1:0] s2_r;
  logic [SAMPLE_W-1:0] qs2_r;
  logic [R_W-1:0]      rs2_r;

  logic [COUNT_W-1:0]  q_r, q_nxt;
  logic [R_W-1:0]      r_r, r_nxt;
  logic [COUNT_W-1:0]  baseline_r, baseline_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [COUNT_W-1:0]  stored_r, stored_nxt;

  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   prod_sh;
  logic [SAMPLE_W-1:0] qs;
  logic [QN_W-1:0]     qn;
  logic [QN_W-1:0]     rem;
  logic [R_W-1:0]      rs;

  logic [COUNT_W-1:0]  q_base;
  logic [R_W-1:0]      r_base;
  logic [R_W:0]        rsum;
  logic [R_W:0]        rsum_red;
  logic                wrap;
  logic [R_W-1:0]      r_new;
  logic [COUNT_W-1:0]  q_new;
  logic [SAMPLE_W:0]   limit;
  logic                touched;
  logic [COUNT_W-1:0]  count_add;

  // Stage 1: sample times reciprocal
  assign prod = {{MUL_W{1'b0}}, sample_in} * {{SAMPLE_W{1'b0}}, MUL_K};

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      s1_r    <= sample_in;
      prod1_r <= prod;
    end
  end

  // Stage 2: quotient and remainder of this sample
  assign prod_sh = prod1_r >> MUL_SH;
  assign qs      = prod_sh[SAMPLE_W-1:0];
  assign qn      = QN_W'(qs) * QN_W'(CALIB_SAMPLES);
  assign rem     = QN_W'(s1_r) - qn;
  assign rs      = rem[R_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      s2_r  <= s1_r;
      qs2_r <= qs;
      rs2_r <= rs;
    end
  end

  // Accumulate quotient and remainder, carry when the remainder wraps
  assign q_base   = ctl.calib_first ? '0 : q_r;
  assign r_base   = ctl.calib_first ? '0 : r_r;
  assign rsum     = {1'b0, r_base} + {1'b0, rs2_r};
  assign wrap     = rsum >= (R_W+1)'(CALIB_SAMPLES);
  assign rsum_red = wrap ? (rsum - (R_W+1)'(CALIB_SAMPLES)) : rsum;
  assign r_new    = rsum_red[R_W-1:0];
  assign q_new    = q_base + qs2_r + {{(COUNT_W-1){1'b0}}, wrap};

  // Touch verdict: sample below baseline minus threshold, signed
  assign limit     = {1'b0, baseline_r} - {1'b0, thr};
  assign touched   = $signed({1'b0, s2_r}) < $signed(limit);
  assign count_add = count_r + scan_interval;

  always_comb begin
    q_nxt        = q_r;
    r_nxt        = r_r;
    baseline_nxt = baseline_r;
    count_nxt    = count_r;
    stored_nxt   = stored_r;
    if (ctl.upd) begin
      if (ctl.calib) begin
        q_nxt = q_new;
        r_nxt = r_new;
        if (ctl.calib_last) begin
          baseline_nxt = q_new;
        end
      end
      if (ctl.scan) begin
        if (touched) begin
          count_nxt = count_add;
        end else begin
          stored_nxt = count_r;
          count_nxt  = '0;
        end
      end
      if (ctl.fetch) begin
        stored_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r        <= '0;
      r_r        <= '0;
      baseline_r <= '0;
      count_r    <= '0;
      stored_r   <= '0;
    end else begin
      q_r        <= q_nxt;
      r_r        <= r_nxt;
      baseline_r <= baseline_nxt;
      count_r    <= count_nxt;
      stored_r   <= stored_nxt;
    end
  end

  assign res.touched = touched;
  assign res.count   = count_nxt;
  assign res.stored  = stored_r;

endmodule

`default_nettype wire

### dv/tb_touch_pad_duration_detector_unit.sv
`timescale 1ns / 1ps

module tb_touch_pad_duration_detector_unit;
  import tpd_pkg::*;

  localparam int CAL_LEN = CALIB_SAMPLES_DEF;
  localparam int LAT_PAD = 6;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_ITEMS = 50;
  localparam int LONG_PHASE = 6;
  localparam int MAX_REPORTS = 100;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    tpd_in_t               item;
    int                    reps;
    bit                    fixed;
    tpd_out_t              want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  tpd_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tpd_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: configuration and detector state
  logic [15:0] lane_thr [2];
  logic [15:0] scan_int;
  logic [15:0] tick_phase;
  int          cal_seen;
  int unsigned cal_acc [2];
  logic [15:0] lane_base [2];
  logic [15:0] lane_count [2];
  logic [15:0] lane_held [2];

  // Stimulus shaping
  bit          idle_on = 1'b1;
  bit          pressed [2];
  logic [15:0] cal_center;

  tpd_out_t    pending_reports [$];
  row_t        plan [$];
  int          errs = 0;
  int          cycles = 0;
  int          reports_seen = 0;
  int          scans_seen = 0;
  int          touches_seen = 0;
  int          calibs_seen = 0;
  int          fetch_hits = 0;
  int          hold_left = 0;

  touch_pad_duration_detector_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the detector by one item and return the report it produces
  function automatic tpd_out_t advance_pad(input tpd_in_t it);
    tpd_out_t rep;
    logic [15:0] smp [2];
    int nxt;
    rep = '0;
    smp[0] = it.sample_ch0;
    smp[1] = it.sample_ch1;
    case (it.req_type)
      REQ_CALIB: begin
        for (int c = 0; c < 2; c++) begin
          if (cal_seen == 0) cal_acc[c] = smp[c];
          else cal_acc[c] = cal_acc[c] + smp[c];
        end
        cal_seen++;
        if (cal_seen >= CAL_LEN) begin
          for (int c = 0; c < 2; c++) lane_base[c] = 16'(cal_acc[c] / CAL_LEN);
          cal_seen = 0;
          rep.calib_done = 1'b1;
        end
      end
      REQ_TICK: begin
        nxt = int'(tick_phase) + 1;
        if (nxt > int'(scan_int)) begin
          tick_phase = '0;
          rep.scanned = 1'b1;
          for (int c = 0; c < 2; c++) begin
            // signed compare: a threshold above the baseline never touches
            if (int'(smp[c]) < int'(lane_base[c]) - int'(lane_thr[c])) begin
              lane_count[c] = lane_count[c] + scan_int;
              if (c == 0) rep.touched_ch0 = 1'b1;
              else rep.touched_ch1 = 1'b1;
            end else begin
              lane_held[c] = lane_count[c];
              lane_count[c] = '0;
            end
          end
        end else begin
          tick_phase = 16'(nxt);
        end
      end
      REQ_FETCH: begin
        rep.fetched_time = lane_held[it.channel];
        lane_held[it.channel] = '0;
      end
      default: ;
    endcase
    rep.count_ch0 = lane_count[0];
    rep.count_ch1 = lane_count[1];
    return rep;
  endfunction

  function automatic row_t item_row(input logic [REQ_W-1:0] req, input logic [15:0] s0,
                                    input logic [15:0] s1, input logic ch, input int reps,
                                    input bit fixed = 1'b0, input tpd_out_t want = '0);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.val = '0;
    r.item.req_type = req;
    r.item.sample_ch0 = s0;
    r.item.sample_ch1 = s1;
    r.item.channel = ch;
    r.reps = reps;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    row_t r;
    r = item_row(REQ_UNUSED, '0, '0, 1'b0, 0);
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // Tick sample that follows the lane's pressed state, with some noise
  function automatic logic [15:0] tick_sample(input int c);
    int lim;
    if ($urandom_range(29, 0) == 0) pressed[c] = ~pressed[c];
    if ($urandom_range(9, 0) == 0) return 16'($urandom);
    lim = int'(lane_base[c]) - int'(lane_thr[c]);
    if (pressed[c] && lim > 0) return 16'($urandom_range(lim - 1, 0));
    return 16'($urandom_range(65535, (lim < 0) ? 0 : lim));
  endfunction

  function automatic logic [15:0] cal_sample();
    int v;
    v = int'(cal_center) + int'($urandom_range(512, 0)) - 256;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic tpd_in_t draw_item(input bit ticks_only);
    tpd_in_t it;
    int pick;
    pick = ticks_only ? 50 : $urandom_range(99, 0);
    it.channel = 1'($urandom);
    it.sample_ch0 = 16'($urandom);
    it.sample_ch1 = 16'($urandom);
    if (pick < 15) begin
      it.req_type = REQ_CALIB;
      if (pick >= 2) begin
        it.sample_ch0 = cal_sample();
        it.sample_ch1 = cal_sample();
      end
    end else if (pick < 80) begin
      it.req_type = REQ_TICK;
      it.sample_ch0 = tick_sample(0);
      it.sample_ch1 = tick_sample(1);
    end else if (pick < 95) begin
      it.req_type = REQ_FETCH;
    end else begin
      it.req_type = REQ_UNUSED;
    end
    return it;
  endfunction

  // Present one item, hold it until the transfer, then queue its report
  task automatic push_item(input tpd_in_t it, input bit fixed, input tpd_out_t want);
    int gap;
    tpd_out_t got;
    gap = idle_on ? $urandom_range(11, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = advance_pad(it);
    pending_reports.push_back(fixed ? want : got);
  endtask

  // Drop valid and wait until every report is back and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THR_CH0: lane_thr[0] = val;
      CFG_THR_CH1: lane_thr[1] = val;
      CFG_SCAN_INT: scan_int = val;
      default: ;
    endcase
  endtask

  task automatic cmp_field(input string fname, input int unsigned exp_v,
                           input int unsigned act_v);
    if (exp_v != act_v) begin
      if (errs < MAX_REPORTS) $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      errs++;
    end
  endtask

  // Result side: random stall after each transfer
  always @(posedge clk) begin : out_pacing
    int n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && out_ready) begin
      n = idle_on ? $urandom_range(11, 0) : 0;
      out_ready <= (n == 0);
      hold_left <= n;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left <= 0;
      out_ready <= 1'b1;
    end
  end

  // Check each result transfer against the oldest queued report
  always @(posedge clk) begin : report_check
    tpd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        if (errs < MAX_REPORTS) $error("result transfer with no report pending");
        errs++;
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        scans_seen += want.scanned;
        touches_seen += want.touched_ch0 + want.touched_ch1;
        calibs_seen += want.calib_done;
        fetch_hits += (want.fetched_time != 0);
        cmp_field("scanned", want.scanned, out_data.scanned);
        cmp_field("touched_ch0", want.touched_ch0, out_data.touched_ch0);
        cmp_field("touched_ch1", want.touched_ch1, out_data.touched_ch1);
        cmp_field("count_ch0", want.count_ch0, out_data.count_ch0);
        cmp_field("count_ch1", want.count_ch1, out_data.count_ch1);
        cmp_field("fetched_time", want.fetched_time, out_data.fetched_time);
        cmp_field("calib_done", want.calib_done, out_data.calib_done);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending", cycles,
               pending_reports.size());
      $display("tb_touch_pad_duration_detector_unit: done, errors");
      $finish;
    end
  end

  initial begin
    tpd_out_t done_only;
    // reset values of the predictor
    lane_thr[0] = '0;
    lane_thr[1] = '0;
    scan_int = SCAN_INT_RST;
    tick_phase = '0;
    cal_seen = 0;
    for (int c = 0; c < 2; c++) begin
      cal_acc[c] = 0;
      lane_base[c] = '0;
      lane_count[c] = '0;
      lane_held[c] = '0;
      pressed[c] = 1'b0;
    end
    cal_center = 16'h8000;
    done_only = '0;
    done_only.calib_done = 1'b1;

    // Directed rows: empty reads, unused code, calibration extremes,
    // touch and release, then threshold extremes at scan every tick
    plan.push_back(item_row(REQ_FETCH, 16'h0000, 16'h0000, 1'b0, 1, 1'b1, '0));
    plan.push_back(item_row(REQ_FETCH, 16'hffff, 16'hffff, 1'b1, 1, 1'b1, '0));
    plan.push_back(item_row(REQ_UNUSED, 16'hffff, 16'hffff, 1'b1, 1, 1'b1, '0));
    plan.push_back(item_row(REQ_TICK, 16'h0000, 16'h0000, 1'b0, 1, 1'b1, '0));
    plan.push_back(item_row(REQ_TICK, 16'h0000, 16'h0000, 1'b0, 10));
    plan.push_back(item_row(REQ_CALIB, 16'hffff, 16'hffff, 1'b0, CAL_LEN - 1));
    plan.push_back(item_row(REQ_CALIB, 16'hffff, 16'hffff, 1'b1, 1, 1'b1, done_only));
    plan.push_back(item_row(REQ_TICK, 16'h0000, 16'h0000, 1'b0, 11));
    plan.push_back(item_row(REQ_TICK, 16'h0000, 16'hffff, 1'b1, 11));
    plan.push_back(item_row(REQ_FETCH, 16'h0000, 16'h0000, 1'b1, 1));
    plan.push_back(item_row(REQ_FETCH, 16'hffff, 16'h0000, 1'b1, 1));
    plan.push_back(item_row(REQ_TICK, 16'hffff, 16'hffff, 1'b0, 11));
    plan.push_back(item_row(REQ_FETCH, 16'h0000, 16'hffff, 1'b0, 1));
    plan.push_back(item_row(REQ_CALIB, 16'h0000, 16'h0000, 1'b0, CAL_LEN));
    plan.push_back(item_row(REQ_TICK, 16'hffff, 16'h0000, 1'b0, 11));
    plan.push_back(cfg_row(CFG_SCAN_INT, 16'h0000));
    plan.push_back(cfg_row(CFG_THR_CH0, 16'hffff));
    plan.push_back(cfg_row(CFG_THR_CH1, 16'h0000));
    plan.push_back(item_row(REQ_CALIB, 16'h8000, 16'h8000, 1'b0, CAL_LEN));
    plan.push_back(item_row(REQ_TICK, 16'h0000, 16'h0000, 1'b0, 2));
    plan.push_back(cfg_row(CFG_THR_CH1, 16'h7fff));
    plan.push_back(cfg_row(CFG_UNUSED, 16'hffff));
    plan.push_back(item_row(REQ_TICK, 16'h0000, 16'h0000, 1'b0, 3));
    plan.push_back(item_row(REQ_FETCH, 16'h0000, 16'h0000, 1'b1, 1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else repeat (plan[i].reps) push_item(plan[i].item, plan[i].fixed, plan[i].want);
    end

    // Random phases; a long interval is followed by a short one so the
    // prescaler sits above the new interval
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_THR_CH0, 16'h0000);
          write_reg(CFG_THR_CH1, 16'hffff);
          write_reg(CFG_SCAN_INT, 16'h0000);
        end
        1: begin
          write_reg(CFG_THR_CH0, 16'hffff);
          write_reg(CFG_THR_CH1, 16'h0000);
          write_reg(CFG_SCAN_INT, 16'h0001);
        end
        2: begin
          write_reg(CFG_THR_CH0, 16'($urandom_range(3000, 0)));
          write_reg(CFG_THR_CH1, 16'($urandom_range(3000, 0)));
          write_reg(CFG_SCAN_INT, 16'($urandom_range(1500, 400)));
        end
        3: begin
          write_reg(CFG_THR_CH0, 16'($urandom));
          write_reg(CFG_THR_CH1, 16'($urandom));
          write_reg(CFG_SCAN_INT, 16'($urandom_range(3, 0)));
        end
        LONG_PHASE: begin
          write_reg(CFG_THR_CH0, 16'($urandom_range(3000, 0)));
          write_reg(CFG_THR_CH1, 16'($urandom_range(3000, 0)));
          write_reg(CFG_SCAN_INT, 16'hffff);
        end
        default: begin
          write_reg(CFG_THR_CH0, 16'($urandom_range(3000, 0)));
          write_reg(CFG_THR_CH1, 16'($urandom_range(3000, 0)));
          write_reg(CFG_SCAN_INT, 16'($urandom_range(20, 0)));
          write_reg(CFG_UNUSED, 16'($urandom));
        end
      endcase
      case ($urandom_range(3, 0))
        0: cal_center = 16'h0000;
        1: cal_center = 16'hffff;
        default: cal_center = 16'($urandom);
      endcase
      idle_on = !(p == 1 || p == 5 || p == LONG_PHASE);
      if (p == LONG_PHASE) begin
        // largest interval: ticks only, run back to back
        repeat (PHASE_ITEMS) push_item(draw_item(1'b1), 1'b0, '0);
      end else begin
        repeat (PHASE_ITEMS) push_item(draw_item(1'b0), 1'b0, '0);
      end
    end

    settle();
    $display("checked %0d reports: %0d scans, %0d touched verdicts, %0d calibrations,",
             reports_seen, scans_seen, touches_seen, calibs_seen);
    $display("%0d nonzero duration reads, %0d mismatches, %0d cycles",
             fetch_hits, errs, cycles);
    if (errs == 0) begin
      $display("tb_touch_pad_duration_detector_unit: done, clean");
    end else begin
      $display("tb_touch_pad_duration_detector_unit: done, errors");
    end
    $finish;
  end

endmodule
